// File: src/tmrs_pkg.sv
// Package with the constants, status codes and tag table of the tagged MAC record scanner.
`timescale 1ns / 1ps

package tmrs_pkg;

  localparam int TagLengthDefault  = 7;
  localparam int CountWidthDefault = 24;
  localparam int MacBytes          = 6;
  localparam int SizeWidth         = 24;
  localparam int TotalWidth        = 24;
  localparam int TagTableLen       = 7;

  localparam logic [SizeWidth-1:0]  SIZE_RESET = 24'd11534336;
  localparam logic [TotalWidth-1:0] TOTAL_MAX  = 24'hFFFFFF;
  localparam logic [47:0]           MAC_ONES   = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] TAG_TABLE [TagTableLen] = '{
    8'h34, 8'h36, 8'h37, 8'h38, 8'h6e, 8'hff, 8'h01
  };

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CONFLICT = 2'd1,
    STATUS_SIZE     = 2'd2,
    STATUS_NO_REC   = 2'd3
  } scan_status_t;

  // Tag bytes beyond the stored table compare against zero.
  function automatic logic [7:0] tag_byte(input int idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < TagTableLen) begin
      b = TAG_TABLE[idx[2:0]];
    end
    return b;
  endfunction

endpackage

// File: src/tmrs_if.sv
// Valid/ready channel interfaces for the scanner's input, result and configuration words.
`timescale 1ns / 1ps

interface tmrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tmrs_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       scan_status;
  logic [47:0]                      mac_address;
  logic [tmrs_pkg::TotalWidth-1:0]  match_total;

  modport source (output valid, output scan_status, output mac_address,
                  output match_total, input ready);
  modport sink (input valid, input scan_status, input mac_address,
                input match_total, output ready);
endinterface

interface tmrs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tmrs_pkg::SizeWidth-1:0]  image_size;

  modport source (output valid, output image_size, input ready);
  modport sink (input valid, input image_size, output ready);
endinterface

// File: src/tagged_mac_record_scanner.sv
// Top level of the tagged MAC record scanner: byte window, tag match and end-of-image report.
//
//   channel  | direction | word                                   | accepted when
//   in_ch    | in        | data_byte, last_byte                   | valid && ready
//   out_ch   | out       | scan_status, mac_address, match_total  | valid && ready
//   cfg_ch   | in        | image_size                             | valid && ready
//
// The block takes one byte per cycle, except while a last byte waits in the input register.
// Each byte is held in the input register; the window check and the counter updates then
// run combinationally as it leaves, and a last byte loads the result register, whose word
// is then valid on out_ch.
// Reset is synchronous and active low; it restores the image size to 11534336.
// A last byte waits in the input register while the previous result is not taken.
`timescale 1ns / 1ps

module tagged_mac_record_scanner #(
  parameter int TAG_LENGTH  = tmrs_pkg::TagLengthDefault,
  parameter int COUNT_WIDTH = tmrs_pkg::CountWidthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  tmrs_in_if.sink     in_ch,
  tmrs_out_if.source  out_ch,
  tmrs_cfg_if.sink    cfg_ch
);

  localparam int WinLen = TAG_LENGTH + tmrs_pkg::MacBytes;
  localparam int FillW  = $clog2(WinLen + 1);
  localparam int CmpW   = (COUNT_WIDTH > tmrs_pkg::SizeWidth) ? COUNT_WIDTH
                                                              : tmrs_pkg::SizeWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [tmrs_pkg::SizeWidth-1:0] image_size_r;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       s1_adv;
  logic       s1_fire;

  logic [7:0]             win_r   [WinLen];
  logic [7:0]             win_nxt [WinLen];
  logic [FillW-1:0]       fill_r;
  logic [FillW-1:0]       fill_nxt;
  logic [47:0]            latched_mac_r;
  logic [47:0]            latched_mac_nxt;
  logic [COUNT_WIDTH-1:0] match_count_r;
  logic [COUNT_WIDTH-1:0] match_count_nxt;
  logic [COUNT_WIDTH-1:0] byte_count_r;
  logic [COUNT_WIDTH-1:0] byte_count_nxt;
  logic                   conflict_r;
  logic                   conflict_nxt;

  logic        tag_hit;
  logic [47:0] mac_cand;
  logic        mac_ok;
  logic        rec_valid;

  logic [CmpW-1:0]                 byte_count_ext;
  logic [CmpW-1:0]                 match_count_ext;
  tmrs_pkg::scan_status_t          status_nxt;
  logic [tmrs_pkg::TotalWidth-1:0] total_nxt;

  logic                            out_valid_r;
  tmrs_pkg::scan_status_t          out_status_r;
  logic [47:0]                     out_mac_r;
  logic [tmrs_pkg::TotalWidth-1:0] out_total_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= tmrs_pkg::SIZE_RESET;
    end else if (cfg_ch.valid) begin
      image_size_r <= cfg_ch.image_size;
    end
  end

  // A byte leaves the input register unless it is last and the result register holds a word not yet taken.
  assign s1_adv      = !in_last_r || !out_valid_r || out_ch.ready;
  assign s1_fire     = in_valid_r && s1_adv;
  assign in_ch.ready = !in_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[WinLen-1] = in_byte_r;
  end

  assign fill_nxt = (fill_r < FillW'(WinLen)) ? fill_r + 1'b1 : fill_r;
  assign byte_count_nxt = (byte_count_r < CountMax) ? byte_count_r + 1'b1 : byte_count_r;

  always_comb begin
    tag_hit = 1'b1;
    for (int i = 0; i < TAG_LENGTH; i++) begin
      if (win_nxt[i] != tmrs_pkg::tag_byte(i)) begin
        tag_hit = 1'b0;
      end
    end
    mac_cand = '0;
    for (int i = 0; i < tmrs_pkg::MacBytes; i++) begin
      mac_cand = {mac_cand[39:0], win_nxt[TAG_LENGTH + i]};
    end
  end

  assign mac_ok    = !mac_cand[40] && (mac_cand != '0) && (mac_cand != tmrs_pkg::MAC_ONES);
  assign rec_valid = (fill_nxt == FillW'(WinLen)) && tag_hit && mac_ok;

  always_comb begin
    latched_mac_nxt = latched_mac_r;
    conflict_nxt    = conflict_r;
    match_count_nxt = match_count_r;
    if (rec_valid) begin
      if (match_count_r == '0) begin
        latched_mac_nxt = mac_cand;
      end else if (mac_cand != latched_mac_r) begin
        conflict_nxt = 1'b1;
      end
      if (match_count_r < CountMax) begin
        match_count_nxt = match_count_r + 1'b1;
      end
    end
  end

  assign byte_count_ext  = CmpW'(byte_count_nxt);
  assign match_count_ext = CmpW'(match_count_nxt);

  always_comb begin
    if (conflict_nxt) begin
      status_nxt = tmrs_pkg::STATUS_CONFLICT;
    end else if (byte_count_ext != CmpW'(image_size_r)) begin
      status_nxt = tmrs_pkg::STATUS_SIZE;
    end else if (match_count_nxt == '0) begin
      status_nxt = tmrs_pkg::STATUS_NO_REC;
    end else begin
      status_nxt = tmrs_pkg::STATUS_OK;
    end
    if (match_count_ext > CmpW'(tmrs_pkg::TOTAL_MAX)) begin
      total_nxt = tmrs_pkg::TOTAL_MAX;
    end else begin
      total_nxt = match_count_ext[tmrs_pkg::TotalWidth-1:0];
    end
  end

  // The window contents need no clearing: the fill count gates every check.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < WinLen; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      latched_mac_r <= '0;
      match_count_r <= '0;
      byte_count_r  <= '0;
      conflict_r    <= 1'b0;
    end else if (s1_fire) begin
      if (in_last_r) begin
        fill_r        <= '0;
        latched_mac_r <= '0;
        match_count_r <= '0;
        byte_count_r  <= '0;
        conflict_r    <= 1'b0;
      end else begin
        fill_r        <= fill_nxt;
        latched_mac_r <= latched_mac_nxt;
        match_count_r <= match_count_nxt;
        byte_count_r  <= byte_count_nxt;
        conflict_r    <= conflict_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && in_last_r) begin
      out_status_r <= status_nxt;
      out_mac_r    <= latched_mac_nxt;
      out_total_r  <= total_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scan_status = out_status_r;
  assign out_ch.mac_address = out_mac_r;
  assign out_ch.match_total = out_total_r;

  // A conflict needs an earlier record, so at least two records have been counted.
  a_conflict_count: assert property (@(posedge clk) disable iff (!rst_n)
    conflict_r |-> (match_count_r > COUNT_WIDTH'(1)))
    else $error("conflict flag set with fewer than two records");

  a_mac_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (match_count_r == '0) |-> (latched_mac_r == '0))
    else $error("latched MAC nonzero without any record");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(WinLen))
    else $error("window fill count beyond window length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && in_last_r) |=> (byte_count_r == '0 && match_count_r == '0 && !conflict_r))
    else $error("scan state not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && in_last_r))
    else $error("result word raised without a last byte");

endmodule

// File: sim/tb_tagged_mac_record_scanner.sv
// Self-checking testbench that streams partition images through the scanner and checks each report.
`timescale 1ns / 1ps

module tb_tagged_mac_record_scanner;

  localparam int WinLen = 13;
  localparam int TagLen = 7;
  localparam logic [23:0] CountTop = 24'hFFFFFF;
  localparam int RandomBytes = 450;
  localparam int DrainCycles = 8;
  localparam int CycleLimit = 400000;
  localparam logic [7:0] MAC_TAG [TagLen] = '{
    8'h34, 8'h36, 8'h37, 8'h38, 8'h6e, 8'hff, 8'h01
  };

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;
  } image_byte_t;

  typedef struct {
    tmrs_pkg::scan_status_t status;
    logic [47:0]            mac;
    logic [23:0]            total;
  } scan_report_t;

  logic clk;
  logic rst_n;

  tmrs_in_if  in_if ();
  tmrs_out_if out_if ();
  tmrs_cfg_if cfg_if ();

  tagged_mac_record_scanner uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  image_byte_t  byte_feed [$];
  scan_report_t pending_reports [$];
  logic [7:0]   image_buf [$];

  logic [7:0]  win [WinLen];
  logic [47:0] first_mac;
  logic [23:0] match_cnt;
  logic [23:0] byte_cnt;
  logic [23:0] size_limit;
  int          win_fill;
  bit          conflict;

  bit presenting;
  int idle_pct;
  int stall_pct;
  int mismatches;
  int cycles;
  int bytes_in;
  int bytes_queued;
  int reports_in;
  int images_queued;
  int status_tally [4];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void clear_scan();
    int i;
    for (i = 0; i < WinLen; i++) begin
      win[i] = 8'h00;
    end
    win_fill = 0;
    first_mac = '0;
    match_cnt = '0;
    byte_cnt = '0;
    conflict = 1'b0;
  endfunction

  function automatic void absorb_byte(logic [7:0] b, logic last);
    logic [47:0]  mac;
    bit           tag_ok;
    scan_report_t rep;
    int           i;
    for (i = 0; i < WinLen - 1; i++) begin
      win[i] = win[i + 1];
    end
    win[WinLen - 1] = b;
    if (win_fill < WinLen) begin
      win_fill++;
    end
    if (byte_cnt != CountTop) begin
      byte_cnt++;
    end
    if (win_fill == WinLen) begin
      tag_ok = 1'b1;
      mac = '0;
      for (i = 0; i < TagLen; i++) begin
        if (win[i] != MAC_TAG[i]) begin
          tag_ok = 1'b0;
        end
      end
      for (i = 0; i < 6; i++) begin
        mac = {mac[39:0], win[TagLen + i]};
      end
      if (tag_ok && !win[TagLen][0] && mac != '0 && mac != '1) begin
        if (match_cnt == 0) begin
          first_mac = mac;
        end else if (mac != first_mac) begin
          conflict = 1'b1;
        end
        if (match_cnt != CountTop) begin
          match_cnt++;
        end
      end
    end
    if (last) begin
      if (conflict) begin
        rep.status = tmrs_pkg::STATUS_CONFLICT;
      end else if (byte_cnt != size_limit) begin
        rep.status = tmrs_pkg::STATUS_SIZE;
      end else if (match_cnt == 0) begin
        rep.status = tmrs_pkg::STATUS_NO_REC;
      end else begin
        rep.status = tmrs_pkg::STATUS_OK;
      end
      rep.mac = first_mac;
      rep.total = match_cnt;
      pending_reports.push_back(rep);
      clear_scan();
    end
  endfunction

  function automatic logic [47:0] unicast_mac();
    logic [47:0] m;
    m = {$urandom, $urandom};
    m[40] = 1'b0;
    if (m == '0) begin
      m[0] = 1'b1;
    end
    return m;
  endfunction

  function automatic void push_tag(int n);
    int i;
    for (i = 0; i < n; i++) begin
      image_buf.push_back(MAC_TAG[i]);
    end
  endfunction

  function automatic void push_mac(logic [47:0] m);
    int i;
    for (i = 0; i < 6; i++) begin
      image_buf.push_back(m[47 - 8 * i -: 8]);
    end
  endfunction

  function automatic void flush_image(int len, bit hold);
    image_byte_t ib;
    int          i;
    for (i = 0; i < len; i++) begin
      ib.data = image_buf[i];
      ib.last = (i == len - 1);
      ib.hold = hold && (i == 0);
      byte_feed.push_back(ib);
    end
    bytes_queued += len;
    images_queued++;
    image_buf.delete();
  endfunction

  // Random images are built from whole records, partial tags and filler bytes.
  function automatic void queue_image(int len, bit hold);
    logic [47:0] own;
    logic [47:0] m;
    int          r;
    int          n;
    own = unicast_mac();
    image_buf.delete();
    while (image_buf.size() < len) begin
      r = $urandom_range(99);
      if (r < 35) begin
        push_tag(TagLen);
        r = $urandom_range(99);
        if (r < 55) begin
          m = own;
        end else if (r < 70) begin
          m = unicast_mac();
        end else if (r < 80) begin
          m = unicast_mac();
          m[40] = 1'b1;
        end else if (r < 88) begin
          m = '0;
        end else if (r < 95) begin
          m = '1;
        end else begin
          m = {$urandom, $urandom};
        end
        push_mac(m);
      end else if (r < 55) begin
        push_tag($urandom_range(1, TagLen - 1));
      end else begin
        for (n = $urandom_range(1, 6); n > 0; n--) begin
          if ($urandom_range(99) < 30) begin
            image_buf.push_back(MAC_TAG[$urandom_range(TagLen - 1)]);
          end else begin
            image_buf.push_back(8'($urandom));
          end
        end
      end
    end
    flush_image(len, hold);
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        idle_pct = 51;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        idle_pct = 0;
        stall_pct = 51;
      end
      default: begin
        idle_pct = 14;
        stall_pct = 14;
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("MISMATCH at report %0d: %s", reports_in, what);
  endtask

  task automatic settle();
    while (byte_feed.size() != 0 || presenting || pending_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_size(logic [23:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.image_size <= v;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    size_limit = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  always @(negedge clk) begin : byte_driver
    image_byte_t nxt;
    if (rst_n && !presenting && byte_feed.size() != 0 &&
        !(byte_feed[0].hold && pending_reports.size() != 0) &&
        $urandom_range(99) >= idle_pct) begin
      nxt = byte_feed.pop_front();
      in_if.valid <= 1'b1;
      in_if.data_byte <= nxt.data;
      in_if.last_byte <= nxt.last;
      presenting = 1'b1;
    end else if (!presenting) begin
      in_if.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : byte_accept
    if (rst_n && in_if.valid && in_if.ready) begin
      absorb_byte(in_if.data_byte, in_if.last_byte);
      presenting = 1'b0;
      bytes_in++;
    end
  end

  always @(negedge clk) begin : report_ready
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : report_monitor
    scan_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      reports_in++;
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected report, status %0d", out_if.scan_status));
      end else begin
        want = pending_reports.pop_front();
        status_tally[want.status]++;
        if (out_if.scan_status !== want.status) begin
          flag_mismatch($sformatf("status %0d, want %0d", out_if.scan_status, want.status));
        end
        if (out_if.mac_address !== want.mac) begin
          flag_mismatch($sformatf("mac %012h, want %012h", out_if.mac_address, want.mac));
        end
        if (out_if.match_total !== want.total) begin
          flag_mismatch($sformatf("total %0d, want %0d", out_if.match_total, want.total));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tagged_mac_record_scanner: mismatch");
      $finish;
    end
  end

  initial begin
    int phase;
    int k;
    int sz;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.image_size = '0;
    rst_n = 1'b0;
    presenting = 1'b0;
    size_limit = tmrs_pkg::SIZE_RESET;
    set_idle(IDLE_NONE);
    clear_scan();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < 3; k++) begin
      queue_image($urandom_range(1, 20), 1'b0);
    end
    settle();

    // A clean record, a lone byte, and a record whose MAC is multicast.
    write_size(24'd13);
    push_tag(TagLen);
    push_mac(48'hFEFF_FFFF_FFFF);
    flush_image(13, 1'b0);
    image_buf.push_back(8'h00);
    flush_image(1, 1'b0);
    push_tag(TagLen);
    push_mac(48'h0100_0000_0000);
    flush_image(13, 1'b0);
    settle();

    write_size(24'd0);
    set_idle(IDLE_SEND);
    for (k = 0; k < 4; k++) begin
      queue_image($urandom_range(1, 24), 1'b0);
    end
    settle();

    write_size(CountTop);
    set_idle(IDLE_RECV);
    for (k = 0; k < 4; k++) begin
      queue_image($urandom_range(1, 24), k == 1);
    end
    settle();

    phase = 0;
    while (phase < 4 || bytes_queued < RandomBytes) begin
      sz = (phase == 2) ? 1 : $urandom_range(13, 24);
      write_size(24'(sz));
      set_idle(idle_mode_t'(phase % 4));
      for (k = 0; k < 6; k++) begin
        queue_image($urandom_range(1) ? sz : $urandom_range(1, 24), k == 2);
      end
      settle();
      phase++;
    end

    $display("Streamed %0d bytes in %0d images and checked %0d reports.",
             bytes_in, images_queued, reports_in);
    $display("Report mix: ok %0d, conflict %0d, size %0d, no record %0d.",
             status_tally[tmrs_pkg::STATUS_OK], status_tally[tmrs_pkg::STATUS_CONFLICT],
             status_tally[tmrs_pkg::STATUS_SIZE], status_tally[tmrs_pkg::STATUS_NO_REC]);
    if (mismatches == 0) begin
      $display("tagged_mac_record_scanner: match");
    end else begin
      $display("tagged_mac_record_scanner: mismatch");
    end
    $finish;
  end

endmodule
